// ----- hw/rtl/bgcopy_pkg.sv -----
// ----------------------------------------------------------------------------
// bgcopy_pkg: shared types and constants of the bit granular copy engine
// Command codes, field widths and the store request structure used by the
// sequencer and the byte store.
// ----------------------------------------------------------------------------
package bgcopy_pkg;

  // Command codes carried on in_command.
  localparam logic [2:0] CMD_WRITE     = 3'd0;
  localparam logic [2:0] CMD_READ      = 3'd1;
  localparam logic [2:0] CMD_COPY      = 3'd2;
  localparam logic [2:0] CMD_FILL_ZERO = 3'd3;
  localparam logic [2:0] CMD_FILL_ONE  = 3'd4;

  // Fixed widths.
  localparam int BYTE_W     = 8;
  localparam int CHUNK_W    = 4;   // holds a chunk length of 0 to 8 bits
  localparam int COUNT_W    = 16;
  localparam int POS_W      = 17;  // bit position, room for offset plus count
  localparam int IDX_W      = 14;  // byte index derived from a bit position
  localparam int ADDR_MAX_W = 20;  // largest store address width

  // One access to the byte store.
  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [BYTE_W-1:0]     wdata;
  } store_req_t;

endpackage

// ----- hw/rtl/bgcopy_store.sv -----
// ----------------------------------------------------------------------------
// bgcopy_store: byte store
// Single write, single read byte memory with a registered read. A read that
// was not issued returns zero.
// ----------------------------------------------------------------------------
module bgcopy_store
  import bgcopy_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  store_req_t        req,
  output logic [BYTE_W-1:0] rdata
);

  localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] q_r;
  logic              ok_r;

  // Memory array with write and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr[ADDR_W-1:0]] <= req.wdata;
    end
    if (req.rd_en) begin
      q_r <= mem[req.addr[ADDR_W-1:0]];
    end
  end

  // Flag marking that the read register holds data of a real read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else begin
      ok_r <= req.rd_en;
    end
  end

  assign rdata = ok_r ? q_r : '0;

endmodule

// ----- hw/rtl/bgcopy_shift_unit.sv -----
// ----------------------------------------------------------------------------
// bgcopy_shift_unit: chunk extract and merge unit
// Pulls up to eight bits out of a two-byte source window and merges them
// into a two-byte destination window, keeping the other destination bits.
// ----------------------------------------------------------------------------
module bgcopy_shift_unit
  import bgcopy_pkg::*;
(
  input  logic [2*BYTE_W-1:0] src_win,
  input  logic [2:0]          src_off,
  input  logic                fill_en,
  input  logic                fill_one,
  input  logic [CHUNK_W-1:0]  chunk_len,
  input  logic [2*BYTE_W-1:0] dst_win,
  input  logic [2:0]          dst_off,
  output logic [2*BYTE_W-1:0] merged,
  output logic                hi_touch
);

  logic [BYTE_W-1:0]   len_mask;
  logic [2*BYTE_W-1:0] src_shift;
  logic [BYTE_W-1:0]   chunk;
  logic [2*BYTE_W-1:0] dst_mask;
  logic [2*BYTE_W-1:0] dst_data;

  // Mask of the low chunk_len bits.
  assign len_mask = 8'hff >> (CHUNK_W'(8) - chunk_len);

  // Source chunk, or the fill pattern.
  assign src_shift = src_win >> src_off;
  assign chunk     = (fill_en ? {BYTE_W{fill_one}} : src_shift[BYTE_W-1:0]) & len_mask;

  // Place the chunk at the destination offset and merge.
  assign dst_mask = {{BYTE_W{1'b0}}, len_mask} << dst_off;
  assign dst_data = {{BYTE_W{1'b0}}, chunk} << dst_off;
  assign merged   = (dst_win & ~dst_mask) | dst_data;
  assign hi_touch = |dst_mask[2*BYTE_W-1:BYTE_W];

endmodule

// ----- hw/rtl/bit_granular_copy_engine.sv -----
// ----------------------------------------------------------------------------
// bit_granular_copy_engine: byte store with bit-granular copy and fill
// Executes byte write, byte read, bit copy and bit fill commands on one
// byte-wide store, one command per transaction, one result per command.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+-----------------------------------------
//   in      | in_valid/in_stall  | command, byte_addr, write_byte, src_bit,
//           |                    | dst_bit, bit_count
//   out     | out_valid/out_stall| read_byte, range_error
//
// Write and read each take one store access; unused codes and zero counts go
// straight to the result. Copy does four reads and up to two writes per chunk
// of up to 8 bits; fill reads only the two destination bytes of each chunk.
// Reset clears control state only; the store contents stay undefined.
// in_stall is high while a command runs; a stalled result holds the block
// before it returns to idle.
// ----------------------------------------------------------------------------
module bit_granular_copy_engine
  import bgcopy_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [2:0]   in_command,
  input  logic [11:0]  in_byte_addr,
  input  logic [7:0]   in_write_byte,
  input  logic [14:0]  in_src_bit,
  input  logic [14:0]  in_dst_bit,
  input  logic [15:0]  in_bit_count,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_read_byte,
  output logic         out_range_error
);

  localparam logic [31:0] TOTAL_BITS = 32'(STORE_BYTES) * 32'd8;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_BYTE_WR = 4'd1;
  localparam logic [3:0] ST_BYTE_RD = 4'd2;
  localparam logic [3:0] ST_RD_CAP  = 4'd3;
  localparam logic [3:0] ST_SRC0    = 4'd4;
  localparam logic [3:0] ST_SRC1    = 4'd5;
  localparam logic [3:0] ST_DST0    = 4'd6;
  localparam logic [3:0] ST_DST1    = 4'd7;
  localparam logic [3:0] ST_WR0     = 4'd8;
  localparam logic [3:0] ST_WR1     = 4'd9;
  localparam logic [3:0] ST_DONE    = 4'd10;

  logic [3:0]         state_r, state_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [11:0]        addr_r, addr_nxt;
  logic [7:0]         wbyte_r, wbyte_nxt;
  logic [POS_W-1:0]   src_pos_r, src_pos_nxt;
  logic [POS_W-1:0]   dst_pos_r, dst_pos_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [7:0]         src_lo_r, src_lo_nxt;
  logic [7:0]         src_hi_r, src_hi_nxt;
  logic [7:0]         dst_lo_r, dst_lo_nxt;
  logic [7:0]         hi_byte_r, hi_byte_nxt;
  logic               hi_wr_r, hi_wr_nxt;
  logic               err_r, err_nxt;
  logic [7:0]         rbyte_r, rbyte_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_read_byte_r, out_read_byte_nxt;
  logic               out_range_error_r, out_range_error_nxt;

  store_req_t         req;
  logic [7:0]         rdata;
  logic [CHUNK_W-1:0] chunk_len;
  logic [IDX_W-1:0]   sb_idx, sb1_idx, db_idx, db1_idx, cmd_idx;
  logic [15:0]        merged;
  logic               hi_touch;
  logic [31:0]        src_end, dst_end;
  logic               accept;

  // True when a byte index lies inside the store.
  function automatic logic in_store(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(STORE_BYTES);
  endfunction

  // Chunk length and the byte indices that the current chunk touches.
  assign chunk_len = (rem_r > COUNT_W'(8)) ? CHUNK_W'(8) : rem_r[CHUNK_W-1:0];
  assign sb_idx    = src_pos_r[POS_W-1:3];
  assign sb1_idx   = sb_idx + IDX_W'(1);
  assign db_idx    = dst_pos_r[POS_W-1:3];
  assign db1_idx   = db_idx + IDX_W'(1);
  assign cmd_idx   = IDX_W'(addr_r);

  // Range ends of the incoming transaction.
  assign src_end = 32'(in_src_bit) + 32'(in_bit_count);
  assign dst_end = 32'(in_dst_bit) + 32'(in_bit_count);

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Byte store.
  bgcopy_store #(
    .STORE_BYTES(STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (rdata)
  );

  // Shared extract and merge unit.
  bgcopy_shift_unit u_shift (
    .src_win   ({src_hi_r, src_lo_r}),
    .src_off   (src_pos_r[2:0]),
    .fill_en   (cmd_r != CMD_COPY),
    .fill_one  (cmd_r == CMD_FILL_ONE),
    .chunk_len (chunk_len),
    .dst_win   ({rdata, dst_lo_r}),
    .dst_off   (dst_pos_r[2:0]),
    .merged    (merged),
    .hi_touch  (hi_touch)
  );

  // Store access for each sequencer state.
  always_comb begin
    req = '0;
    case (state_r)
      ST_BYTE_WR: begin
        req.wr_en = in_store(cmd_idx);
        req.addr  = ADDR_MAX_W'(addr_r);
        req.wdata = wbyte_r;
      end
      ST_BYTE_RD: begin
        req.rd_en = in_store(cmd_idx);
        req.addr  = ADDR_MAX_W'(addr_r);
      end
      ST_SRC0: begin
        req.rd_en = in_store(sb_idx);
        req.addr  = ADDR_MAX_W'(sb_idx);
      end
      ST_SRC1: begin
        req.rd_en = in_store(sb1_idx);
        req.addr  = ADDR_MAX_W'(sb1_idx);
      end
      ST_DST0: begin
        req.rd_en = in_store(db_idx);
        req.addr  = ADDR_MAX_W'(db_idx);
      end
      ST_DST1: begin
        req.rd_en = in_store(db1_idx);
        req.addr  = ADDR_MAX_W'(db1_idx);
      end
      ST_WR0: begin
        req.wr_en = in_store(db_idx);
        req.addr  = ADDR_MAX_W'(db_idx);
        req.wdata = merged[7:0];
      end
      ST_WR1: begin
        req.wr_en = hi_wr_r;
        req.addr  = ADDR_MAX_W'(db1_idx);
        req.wdata = hi_byte_r;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt           = state_r;
    cmd_nxt             = cmd_r;
    addr_nxt            = addr_r;
    wbyte_nxt           = wbyte_r;
    src_pos_nxt         = src_pos_r;
    dst_pos_nxt         = dst_pos_r;
    rem_nxt             = rem_r;
    src_lo_nxt          = src_lo_r;
    src_hi_nxt          = src_hi_r;
    dst_lo_nxt          = dst_lo_r;
    hi_byte_nxt         = hi_byte_r;
    hi_wr_nxt           = hi_wr_r;
    err_nxt             = err_r;
    rbyte_nxt           = rbyte_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_read_byte_nxt   = out_read_byte_r;
    out_range_error_nxt = out_range_error_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_command;
          addr_nxt    = in_byte_addr;
          wbyte_nxt   = in_write_byte;
          src_pos_nxt = POS_W'(in_src_bit);
          dst_pos_nxt = POS_W'(in_dst_bit);
          rem_nxt     = in_bit_count;
          rbyte_nxt   = '0;
          err_nxt     = 1'b0;
          state_nxt   = ST_DONE;
          case (in_command)
            CMD_WRITE: begin
              err_nxt   = !in_store(IDX_W'(in_byte_addr));
              state_nxt = ST_BYTE_WR;
            end
            CMD_READ: begin
              err_nxt   = !in_store(IDX_W'(in_byte_addr));
              state_nxt = ST_BYTE_RD;
            end
            CMD_COPY: begin
              err_nxt = (src_end > TOTAL_BITS) || (dst_end > TOTAL_BITS);
              if (in_bit_count != '0) begin
                state_nxt = ST_SRC0;
              end
            end
            CMD_FILL_ZERO, CMD_FILL_ONE: begin
              err_nxt = (dst_end > TOTAL_BITS);
              if (in_bit_count != '0) begin
                state_nxt = ST_DST0;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_BYTE_WR: begin
        state_nxt = ST_DONE;
      end
      ST_BYTE_RD: begin
        state_nxt = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        rbyte_nxt = rdata;
        state_nxt = ST_DONE;
      end
      ST_SRC0: begin
        state_nxt = ST_SRC1;
      end
      ST_SRC1: begin
        src_lo_nxt = rdata;
        state_nxt  = ST_DST0;
      end
      ST_DST0: begin
        src_hi_nxt = rdata;
        state_nxt  = ST_DST1;
      end
      ST_DST1: begin
        dst_lo_nxt = rdata;
        state_nxt  = ST_WR0;
      end
      ST_WR0: begin
        hi_byte_nxt = merged[15:8];
        hi_wr_nxt   = hi_touch && in_store(db1_idx);
        state_nxt   = ST_WR1;
      end
      ST_WR1: begin
        // Advance to the next chunk.
        src_pos_nxt = src_pos_r + POS_W'(chunk_len);
        dst_pos_nxt = dst_pos_r + POS_W'(chunk_len);
        rem_nxt     = rem_r - COUNT_W'(chunk_len);
        if (rem_r == COUNT_W'(chunk_len)) begin
          state_nxt = ST_DONE;
        end else if (cmd_r == CMD_COPY) begin
          state_nxt = ST_SRC0;
        end else begin
          state_nxt = ST_DST0;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_read_byte_nxt   = rbyte_r;
          out_range_error_nxt = err_r;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cmd_r             <= cmd_nxt;
    addr_r            <= addr_nxt;
    wbyte_r           <= wbyte_nxt;
    src_pos_r         <= src_pos_nxt;
    dst_pos_r         <= dst_pos_nxt;
    rem_r             <= rem_nxt;
    src_lo_r          <= src_lo_nxt;
    src_hi_r          <= src_hi_nxt;
    dst_lo_r          <= dst_lo_nxt;
    hi_byte_r         <= hi_byte_nxt;
    hi_wr_r           <= hi_wr_nxt;
    err_r             <= err_nxt;
    rbyte_r           <= rbyte_nxt;
    out_read_byte_r   <= out_read_byte_nxt;
    out_range_error_r <= out_range_error_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_byte   = out_read_byte_r;
  assign out_range_error = out_range_error_r;

  // The single store port never reads and writes in one cycle.
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.rd_en && req.wr_en))
    else $error("store read and write in the same cycle");

  // Writes stay inside the store.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> (32'(req.addr) < 32'(STORE_BYTES)))
    else $error("store write beyond the last byte");

  // A chunk is never processed with nothing left to move.
  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR0 || state_r == ST_WR1) |-> (rem_r != '0))
    else $error("chunk step with zero remaining bits");

  // A new result appears only on leaving the done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the done state");

  // A pending result is not overwritten while stalled.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_read_byte_r)
                                    && $stable(out_range_error_r)))
    else $error("stalled result changed");

endmodule

// ----- test/bgcopy_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcopy_result_checker: result predictor and comparator for the copy engine
// Watches both channels of the bit granular copy engine. Every accepted
// command is applied to a private image of the byte store, and the reply it
// must produce is queued. Every accepted result is compared field by field
// with the oldest queued reply. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module bgcopy_result_checker
  import bgcopy_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [11:0] in_byte_addr,
  input  logic [7:0]  in_write_byte,
  input  logic [14:0] in_src_bit,
  input  logic [14:0] in_dst_bit,
  input  logic [15:0] in_bit_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_read_byte,
  input  logic        out_range_error,
  output int          fail_count,
  output int          pending
);

  localparam int unsigned TOTAL_BITS = STORE_BYTES * 8;
  localparam int unsigned CHUNK_BITS = 8;
  localparam int          IMG_IDX_W  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  // Where the bits of one chunk come from.
  typedef enum logic [1:0] {
    BITS_FROM_SOURCE,
    BITS_ZERO,
    BITS_ONE
  } bit_source_t;

  // One reply the engine owes, with its command kept for diagnostics.
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] read_byte;
    logic       range_error;
  } reply_t;

  logic [7:0]  store_image [STORE_BYTES];
  reply_t      expected_replies [$];
  int unsigned reply_index;

  initial begin
    fail_count  = 0;
    pending     = 0;
    reply_index = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Bits past the end of the store read as zero.
  function automatic logic fetch_bit(input int unsigned pos);
    if (pos >= TOTAL_BITS) begin
      return 1'b0;
    end
    return store_image[pos[IMG_IDX_W+2:3]][pos[2:0]];
  endfunction

  // Bits past the end of the store are dropped.
  function automatic void place_bit(input int unsigned pos, input logic value);
    if (pos < TOTAL_BITS) begin
      store_image[pos[IMG_IDX_W+2:3]][pos[2:0]] = value;
    end
  endfunction

  // Forward chunked move: each chunk is gathered in full before it is
  // merged, which fixes the outcome of overlapping copies.
  function automatic void move_bits(input int unsigned src, input int unsigned dst,
                                    input int unsigned count, input bit_source_t source);
    logic [7:0]  chunk;
    int unsigned n;
    int unsigned k;
    while (count != 0) begin
      n = (count > CHUNK_BITS) ? CHUNK_BITS : count;
      chunk = (source == BITS_ONE) ? 8'hff : 8'h00;
      if (source == BITS_FROM_SOURCE) begin
        for (k = 0; k < n; k++) begin
          chunk[k[2:0]] = fetch_bit(src + k);
        end
      end
      for (k = 0; k < n; k++) begin
        place_bit(dst + k, chunk[k[2:0]]);
      end
      src   += n;
      dst   += n;
      count -= n;
    end
  endfunction

  // Applies one command to the store image and returns the reply it causes.
  function automatic reply_t apply_command(input logic [2:0] command,
                                           input logic [11:0] byte_addr,
                                           input logic [7:0] write_byte,
                                           input logic [14:0] src_bit,
                                           input logic [14:0] dst_bit,
                                           input logic [15:0] bit_count);
    reply_t      reply;
    int unsigned src;
    int unsigned dst;
    int unsigned count;
    reply         = '0;
    reply.command = command;
    src           = 32'(src_bit);
    dst           = 32'(dst_bit);
    count         = 32'(bit_count);
    case (command)
      CMD_WRITE: begin
        if (32'(byte_addr) < STORE_BYTES) store_image[IMG_IDX_W'(byte_addr)] = write_byte;
        else reply.range_error = 1'b1;
      end
      CMD_READ: begin
        if (32'(byte_addr) < STORE_BYTES) reply.read_byte = store_image[IMG_IDX_W'(byte_addr)];
        else reply.range_error = 1'b1;
      end
      CMD_COPY: begin
        if (src + count > TOTAL_BITS || dst + count > TOTAL_BITS) begin
          reply.range_error = 1'b1;
        end
        move_bits(src, dst, count, BITS_FROM_SOURCE);
      end
      CMD_FILL_ZERO, CMD_FILL_ONE: begin
        if (dst + count > TOTAL_BITS) begin
          reply.range_error = 1'b1;
        end
        move_bits(0, dst, count, (command == CMD_FILL_ONE) ? BITS_ONE : BITS_ZERO);
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  // Results are checked before the command of the same edge is queued; a
  // result can never belong to a command accepted at the same edge.
  always @(posedge clk) begin : watch_channels
    reply_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("result %0d unexpected: read_byte %02h range_error %0b",
                                    reply_index, out_read_byte, out_range_error));
        end else begin
          want = expected_replies.pop_front();
          if (out_read_byte !== want.read_byte || out_range_error !== want.range_error) begin
            report_mismatch($sformatf("result %0d cmd %0d: got %02h/%0b, expected %02h/%0b",
                                      reply_index, want.command,
                                      out_read_byte, out_range_error,
                                      want.read_byte, want.range_error));
          end
        end
        reply_index++;
      end
      if (in_valid && !in_stall) begin
        expected_replies.push_back(apply_command(in_command, in_byte_addr, in_write_byte,
                                                 in_src_bit, in_dst_bit, in_bit_count));
      end
    end
    pending <= expected_replies.size();
  end

endmodule

// ----- test/tb_bit_granular_copy_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bit_granular_copy_engine: testbench of the bit granular copy engine
// Clears the whole store first, then runs a directed set of byte accesses,
// unaligned and overlapping copies, fills and out-of-range commands, then
// random commands with random idling on both channels. A separate checker
// predicts and compares the results; this module drives and decides.
// ----------------------------------------------------------------------------
module tb_bit_granular_copy_engine;
  import bgcopy_pkg::*;

  localparam int unsigned STORE_BYTES    = 4096;
  localparam logic [2:0]  CMD_SPARE_LO   = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI   = 3'd7;
  localparam int          RANDOM_ITEMS   = 1376;
  localparam int          QUIET_ITEMS    = 150;
  localparam int          HOLD_AFTER     = 300;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          TAIL_CYCLES    = 20;
  localparam int          WATCHDOG_LIMIT = 100000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [11:0] in_byte_addr;
  logic [7:0]  in_write_byte;
  logic [14:0] in_src_bit;
  logic [14:0] in_dst_bit;
  logic [15:0] in_bit_count;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_byte;
  logic        out_range_error;

  int          fail_count;
  int          pending;
  int          accepted_items = 0;
  int          idle_cycles    = 0;
  int          gap_pct        = 20;
  int          stall_mode     = 2;
  logic [7:0]  mode_timer     = '0;
  bit          quiet          = 1'b0;
  bit          long_hold_done = 1'b0;

  bit_granular_copy_engine #(
    .STORE_BYTES(STORE_BYTES)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_byte_addr   (in_byte_addr),
    .in_write_byte  (in_write_byte),
    .in_src_bit     (in_src_bit),
    .in_dst_bit     (in_dst_bit),
    .in_bit_count   (in_bit_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_byte  (out_read_byte),
    .out_range_error(out_range_error)
  );

  bgcopy_result_checker #(
    .STORE_BYTES(STORE_BYTES)
  ) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_byte_addr   (in_byte_addr),
    .in_write_byte  (in_write_byte),
    .in_src_bit     (in_src_bit),
    .in_dst_bit     (in_dst_bit),
    .in_bit_count   (in_bit_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_byte  (out_read_byte),
    .out_range_error(out_range_error),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one command and returns at the edge that accepts it, sometimes
  // followed by an idle gap. Valid stays high into the next command.
  task automatic send_cmd(input logic [2:0] command, input logic [11:0] byte_addr,
                          input logic [7:0] write_byte, input logic [14:0] src_bit,
                          input logic [14:0] dst_bit, input logic [15:0] bit_count);
    in_valid      <= 1'b1;
    in_command    <= command;
    in_byte_addr  <= byte_addr;
    in_write_byte <= write_byte;
    in_src_bit    <= src_bit;
    in_dst_bit    <= dst_bit;
    in_bit_count  <= bit_count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accepted_items++;
    if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Stops offering until every queued reply has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus and verdict.
  initial begin
    int          n;
    int          pick;
    int unsigned base;
    logic [2:0]  command;
    logic [14:0] src;
    logic [14:0] dst;
    int          count;
    int          p;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_WRITE;
    in_byte_addr  = '0;
    in_write_byte = '0;
    in_src_bit    = '0;
    in_dst_bit    = '0;
    in_bit_count  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Clear the whole store first so that no byte is ever read undefined.
    send_cmd(CMD_FILL_ZERO, 12'($urandom), 8'($urandom), 15'($urandom), 15'd0, 16'd32768);

    // Byte accesses at both ends of the store, with extreme data.
    send_cmd(CMD_WRITE, 12'd0, 8'ha5, 15'($urandom), 15'($urandom), 16'($urandom));
    send_cmd(CMD_WRITE, 12'd4095, 8'hff, 15'($urandom), 15'($urandom), 16'($urandom));
    send_cmd(CMD_WRITE, 12'd1, 8'h00, 15'($urandom), 15'($urandom), 16'($urandom));
    send_cmd(CMD_READ, 12'd0, 8'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
    send_cmd(CMD_READ, 12'd4095, 8'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
    send_cmd(CMD_READ, 12'd1, 8'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));

    // Unaligned copy, then overlapping copies in both directions.
    send_cmd(CMD_COPY, 12'($urandom), 8'($urandom), 15'd0, 15'd13, 16'd19);
    send_cmd(CMD_COPY, 12'($urandom), 8'($urandom), 15'd3, 15'd5, 16'd30);
    send_cmd(CMD_COPY, 12'($urandom), 8'($urandom), 15'd40, 15'd33, 16'd25);

    // A zero count changes nothing, even at the last source bit.
    send_cmd(CMD_COPY, 12'($urandom), 8'($urandom), 15'd32767, 15'd200, 16'd0);

    // Short fills inside a byte and over one whole aligned byte.
    send_cmd(CMD_FILL_ONE, 12'($urandom), 8'($urandom), 15'($urandom), 15'd9, 16'd1);
    send_cmd(CMD_FILL_ONE, 12'($urandom), 8'($urandom), 15'($urandom), 15'd64, 16'd8);
    send_cmd(CMD_FILL_ZERO, 12'($urandom), 8'($urandom), 15'($urandom), 15'd66, 16'd3);

    // Ranges that run past the end of the store.
    send_cmd(CMD_COPY, 12'($urandom), 8'($urandom), 15'd32760, 15'd100, 16'd20);
    send_cmd(CMD_COPY, 12'($urandom), 8'($urandom), 15'd8, 15'd32765, 16'd10);
    send_cmd(CMD_FILL_ZERO, 12'($urandom), 8'($urandom), 15'($urandom), 15'd32760, 16'd9);
    send_cmd(CMD_FILL_ONE, 12'($urandom), 8'($urandom), 15'($urandom), 15'd32767,
             16'd32768);
    send_cmd(CMD_COPY, 12'($urandom), 8'($urandom), 15'd32767, 15'd0, 16'd32768);

    // Exactly reaching the end is still in range.
    send_cmd(CMD_COPY, 12'($urandom), 8'($urandom), 15'd0, 15'd32767, 16'd1);

    // Unused codes do nothing.
    send_cmd(CMD_SPARE_LO, 12'($urandom), 8'($urandom), 15'($urandom), 15'($urandom),
             16'($urandom));
    send_cmd(CMD_SPARE_HI, 12'($urandom), 8'($urandom), 15'($urandom), 15'($urandom),
             16'($urandom));
    send_cmd(CMD_READ, 12'd4095, 8'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
    send_cmd(CMD_READ, 12'd12, 8'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
    wait_for_drain();

    // Random commands: mostly short runs, some overlaps and end cases, and
    // a handful of very long ones.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) gap_pct = $urandom_range(0, 3) * 8;
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (n == RANDOM_ITEMS / 2) wait_for_drain();

      pick = $urandom_range(0, 99);
      if (pick < 18) command = CMD_WRITE;
      else if (pick < 36) command = CMD_READ;
      else if (pick < 70) command = CMD_COPY;
      else if (pick < 80) command = CMD_FILL_ZERO;
      else if (pick < 92) command = CMD_FILL_ONE;
      else command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));

      src = 15'($urandom);
      dst = 15'($urandom);
      case ($urandom_range(0, 9))
        6, 7: begin
          base = $urandom_range(20, 32000);
          src  = 15'(base);
          dst  = 15'(base + $urandom_range(0, 40) - 20);
        end
        8: src = 15'(32767 - $urandom_range(0, 80));
        9: dst = 15'(32767 - $urandom_range(0, 80));
        default: begin
        end
      endcase

      p = $urandom_range(0, 999);
      if (p < 3) count = $urandom_range(4096, 32768);
      else if (p < 100) count = $urandom_range(0, 300);
      else if (p < 160) count = $urandom_range(0, 9);
      else count = $urandom_range(1, 64);

      send_cmd(command, 12'($urandom), 8'($urandom), src, dst, 16'(count));
    end

    // Wait out every reply, then keep watching for stray results.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // The density of result stalls changes each time mode_timer wraps, including
  // stretches with none at all.
  always @(posedge clk) begin
    mode_timer <= mode_timer + 8'd1;
    if (mode_timer == 8'hff) stall_mode <= $urandom_range(0, 3);
  end

  // Result stalls: one long hold-off that backs the engine up, then
  // random bursts until the quiet tail.
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!long_hold_done && accepted_items >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (!quiet && stall_mode != 0 && $urandom_range(1, 100) <= stall_mode * 6) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d replies outstanding",
               idle_cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
